FILE: rtl/core/vcpi_pkg.sv
package vcpi_pkg;

    // VRAM depth; must be a power of two so the address wraps by truncation
    localparam int VRAM_BYTES = 131072;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);

    // CPU port action codes
    localparam logic [2:0] ACT_VRAM_RD  = 3'd0;
    localparam logic [2:0] ACT_VRAM_WR  = 3'd1;
    localparam logic [2:0] ACT_CTRL_WR  = 3'd2;
    localparam logic [2:0] ACT_PAL_WR   = 3'd3;
    localparam logic [2:0] ACT_INDIR_WR = 3'd4;

    // Registers whose contents feed back into the port logic
    localparam logic [5:0] REG_MODE0   = 6'd0;
    localparam logic [5:0] REG_BANK    = 6'd14;
    localparam logic [5:0] REG_PAL_PTR = 6'd16;
    localparam logic [5:0] REG_IND_PTR = 6'd17;

    localparam logic [7:0] IND_PTR_MASK = 8'hbf;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_VRAM_RD,
        OP_VRAM_WR,
        OP_CTRL,
        OP_PAL,
        OP_IND
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       reg_write_valid;
        logic [5:0] reg_write_index;
        logic [7:0] reg_write_value;
        logic       palette_valid;
        logic [3:0] palette_index;
        logic [7:0] palette_first;
        logic [7:0] palette_second;
    } t_result;

endpackage

FILE: rtl/core/vcpi_in_if.sv
interface vcpi_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

FILE: rtl/core/vcpi_out_if.sv
interface vcpi_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       reg_write_valid;
    logic [5:0] reg_write_index;
    logic [7:0] reg_write_value;
    logic       palette_valid;
    logic [3:0] palette_index;
    logic [7:0] palette_first;
    logic [7:0] palette_second;

    modport source (
        output valid, output read_data, output reg_write_valid, output reg_write_index,
        output reg_write_value, output palette_valid, output palette_index,
        output palette_first, output palette_second, input ready
    );
    modport sink (
        input valid, input read_data, input reg_write_valid, input reg_write_index,
        input reg_write_value, input palette_valid, input palette_index,
        input palette_first, input palette_second, output ready
    );
endinterface

FILE: rtl/core/video_controller_port_interface.sv
// An accepted input item enters the command queue; when popped, the entry executes and
// loads the result register; a stalled output holds the entry in the queue.
// Throughput: one item per cycle unless the output stalls; each item makes at most one
// access to the single-port VRAM, and the 2-entry queue keeps input and output decoupled.
// Reset (i_rst_n low, synchronous): clears the queue, output valid, address
// counter, port latches and tracked registers; VRAM contents are left as they are.
module video_controller_port_interface (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    vcpi_in_if.sink    i_in,
    vcpi_out_if.source o_out
);
    import vcpi_pkg::*;

    logic q_full;
    logic push;
    logic pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    vcpi_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    vcpi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    vcpi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (pop),
        .o_out         (o_out)
    );
endmodule

FILE: rtl/core/vcpi_front.sv
module vcpi_front (
    vcpi_in_if.sink        i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output vcpi_pkg::t_cmd o_cmd
);
    import vcpi_pkg::*;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd.data = i_in.data_byte;
        case (i_in.action)
            ACT_VRAM_RD:  o_cmd.op = OP_VRAM_RD;
            ACT_VRAM_WR:  o_cmd.op = OP_VRAM_WR;
            ACT_CTRL_WR:  o_cmd.op = OP_CTRL;
            ACT_PAL_WR:   o_cmd.op = OP_PAL;
            ACT_INDIR_WR: o_cmd.op = OP_IND;
            default:      o_cmd.op = OP_NONE;
        endcase
    end
endmodule

FILE: rtl/core/vcpi_fifo.sv
module vcpi_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vcpi_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output vcpi_pkg::t_cmd o_cmd
);
    import vcpi_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

FILE: rtl/core/vcpi_back.sv
module vcpi_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    input  logic           i_q_valid,
    input  vcpi_pkg::t_cmd i_cmd,
    output logic           o_pop,
    vcpi_out_if.source     o_out
);
    import vcpi_pkg::*;

    // VRAM and read path
    logic [7:0]         r_vram [VRAM_BYTES];
    logic [7:0]         r_mem_q;
    logic [7:0]         r_lat;
    logic               r_lat_mem;
    logic               n_lat_mem;
    logic [7:0]         n_lat;

    // Port state; only registers that feed back into this logic are kept
    logic               r_ilv;
    logic [13:0]        r_addr_cnt, n_addr_cnt;
    logic [7:0]         r_sdl, n_sdl;
    logic               r_cpend, n_cpend;
    logic               r_ppend, n_ppend;
    logic [1:0]         r_reg0_mode, n_reg0_mode;
    logic [2:0]         r_reg14, n_reg14;
    logic [3:0]         r_reg16, n_reg16;
    logic [7:0]         r_reg17, n_reg17;

    t_result            r_out;
    t_result            res;
    logic               r_out_valid;

    logic               mem_rd;
    logic               mem_wr;
    logic [13:0]        base;
    logic [13:0]        cnt_inc;
    logic [16:0]        full_addr;
    logic [16:0]        rot_addr;
    logic [VRAM_AW-1:0] mem_addr;
    logic [7:0]         latch_cur;
    logic               rw_valid;
    logic [5:0]         rw_idx;
    logic [7:0]         rw_val;

    assign o_pop     = i_q_valid && (!r_out_valid || o_out.ready);
    assign latch_cur = r_lat_mem ? r_mem_q : r_lat;

    always_comb begin
        n_addr_cnt  = r_addr_cnt;
        n_sdl       = r_sdl;
        n_cpend     = r_cpend;
        n_ppend     = r_ppend;
        n_reg0_mode = r_reg0_mode;
        n_reg14     = r_reg14;
        n_reg16     = r_reg16;
        n_reg17     = r_reg17;
        n_lat       = r_lat;
        n_lat_mem   = r_lat_mem;
        res         = '0;
        mem_rd      = 1'b0;
        mem_wr      = 1'b0;
        rw_valid    = 1'b0;
        rw_idx      = '0;
        rw_val      = '0;
        base        = r_addr_cnt;

        if (o_pop) begin
            case (i_cmd.op)
                OP_VRAM_RD: begin
                    res.read_data = latch_cur;
                    n_cpend       = 1'b0;
                    mem_rd        = 1'b1;
                end
                OP_VRAM_WR: begin
                    n_cpend   = 1'b0;
                    mem_wr    = 1'b1;
                    n_lat     = i_cmd.data;
                    n_lat_mem = 1'b0;
                end
                OP_CTRL: begin
                    if (r_cpend) begin
                        n_cpend = 1'b0;
                        if (i_cmd.data[7]) begin
                            if (!i_cmd.data[6]) begin
                                rw_valid = 1'b1;
                                rw_idx   = i_cmd.data[5:0];
                                rw_val   = r_sdl;
                            end
                        end else begin
                            base       = {i_cmd.data[5:0], r_sdl};
                            n_addr_cnt = base;
                            // address set-up without the write flag prefetches
                            mem_rd     = !i_cmd.data[6];
                        end
                    end else begin
                        n_cpend = 1'b1;
                        n_sdl   = i_cmd.data;
                    end
                end
                OP_PAL: begin
                    if (r_ppend) begin
                        res.palette_valid  = 1'b1;
                        res.palette_index  = r_reg16;
                        res.palette_first  = r_sdl;
                        res.palette_second = i_cmd.data;
                        n_reg16            = r_reg16 + 4'd1;
                    end else begin
                        n_sdl = i_cmd.data;
                    end
                    n_ppend = !r_ppend;
                end
                OP_IND: begin
                    n_sdl = i_cmd.data;
                    if (r_reg17[5:0] != REG_IND_PTR) begin
                        rw_valid = 1'b1;
                        rw_idx   = r_reg17[5:0];
                        rw_val   = i_cmd.data;
                    end
                    if (!r_reg17[7]) begin
                        n_reg17 = {2'b00, r_reg17[5:0] + 6'd1};
                    end
                end
                default: begin
                end
            endcase
        end

        // post-increment the counter; advance the bank on wrap in extended modes
        cnt_inc = base + 14'd1;
        if (mem_rd || mem_wr) begin
            n_addr_cnt = cnt_inc;
            if (cnt_inc == 14'd0 && r_reg0_mode != 2'b00) begin
                n_reg14 = r_reg14 + 3'd1;
            end
        end
        if (mem_rd) begin
            n_lat_mem = 1'b1;
        end

        if (rw_valid) begin
            res.reg_write_valid = 1'b1;
            res.reg_write_index = rw_idx;
            res.reg_write_value = rw_val;
            case (rw_idx)
                REG_MODE0:   n_reg0_mode = rw_val[3:2];
                REG_BANK:    n_reg14     = rw_val[2:0];
                REG_PAL_PTR: begin
                    n_reg16 = rw_val[3:0];
                    n_ppend = 1'b0;
                end
                REG_IND_PTR: n_reg17 = rw_val & IND_PTR_MASK;
                default: begin
                end
            endcase
        end
    end

    assign full_addr = {r_reg14, base};
    assign rot_addr  = r_ilv ? {full_addr[0], full_addr[16:1]} : full_addr;
    assign mem_addr  = rot_addr[VRAM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_vram[mem_addr] <= i_cmd.data;
        end
        if (mem_rd) begin
            r_mem_q <= r_vram[mem_addr];
        end
        if (o_pop) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ilv       <= 1'b0;
            r_addr_cnt  <= '0;
            r_sdl       <= '0;
            r_cpend     <= 1'b0;
            r_ppend     <= 1'b0;
            r_reg0_mode <= '0;
            r_reg14     <= '0;
            r_reg16     <= '0;
            r_reg17     <= '0;
            r_lat       <= '0;
            r_lat_mem   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ilv <= i_cfg_wr_data;
            end
            r_addr_cnt  <= n_addr_cnt;
            r_sdl       <= n_sdl;
            r_cpend     <= n_cpend;
            r_ppend     <= n_ppend;
            r_reg0_mode <= n_reg0_mode;
            r_reg14     <= n_reg14;
            r_reg16     <= n_reg16;
            r_reg17     <= n_reg17;
            r_lat       <= n_lat;
            r_lat_mem   <= n_lat_mem;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.read_data       = r_out.read_data;
    assign o_out.reg_write_valid = r_out.reg_write_valid;
    assign o_out.reg_write_index = r_out.reg_write_index;
    assign o_out.reg_write_value = r_out.reg_write_value;
    assign o_out.palette_valid   = r_out.palette_valid;
    assign o_out.palette_index   = r_out.palette_index;
    assign o_out.palette_first   = r_out.palette_first;
    assign o_out.palette_second  = r_out.palette_second;

    a_pop_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped command did not reach the output register");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.reg_write_valid && r_out.palette_valid))
        else $error("register and palette event in one result");

    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_data != 8'd0)
            |-> (!r_out.reg_write_valid && !r_out.palette_valid))
        else $error("read data together with an event");

    a_ptr_bit6: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_reg17[6])
        else $error("indirect pointer bit 6 set");

    a_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_rd && mem_wr))
        else $error("VRAM read and write in one cycle");
endmodule

FILE: sim/tb_video_controller_port_interface.sv
`timescale 1ns / 1ps

module tb_video_controller_port_interface;
    import vcpi_pkg::*;

    localparam logic [5:0] REG_PATGEN     = 6'd4;
    localparam logic [5:0] REG_MODE2      = 6'd9;
    localparam logic [5:0] REG_TEXT_COLOR = 6'd12;
    localparam logic [5:0] REG_BLINK      = 6'd13;
    localparam logic [5:0] REG_STATUS_PTR = 6'd15;
    localparam logic [5:0] REG_CMD_FIRST  = 6'd32;
    localparam logic [5:0] REG_CMD_LAST   = 6'd46;
    localparam logic [5:0] REG_TOP        = 6'd63;

    localparam logic [7:0] CTL_REG_SEL     = 8'h80;
    localparam logic [7:0] CTL_NO_READ     = 8'h40;
    localparam logic [7:0] IND_HOLD        = 8'h80;
    localparam logic [7:0] MODE0_WRAP_BITS = 8'h0c;

    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    vcpi_in_if  in_ch();
    vcpi_out_if out_ch();

    video_controller_port_interface i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (in_ch),
        .o_out        (out_ch)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Port state as the CPU sees it
    logic [7:0]  vram_model [VRAM_BYTES];
    bit          vram_written [VRAM_BYTES];
    logic [7:0]  regs_model [64];
    logic [7:0]  readahead_model  = '0;
    logic [13:0] addr_model       = '0;
    logic [7:0]  data_latch_model = '0;
    bit          ctrl_pend_model  = 1'b0;
    bit          pal_pend_model   = 1'b0;
    bit          interleave_model = 1'b0;

    t_result port_results_q [$];

    int err_count       = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int reg_events      = 0;
    int pal_events      = 0;
    int mode_writes     = 0;
    int src_max_gap     = 0;
    int snk_max_stall   = 0;
    int sink_hold_cycles = 0;

    function automatic int vram_index(input logic [13:0] cnt);
        logic [16:0] a;
        a = {regs_model[REG_BANK][2:0], cnt};
        if (interleave_model) a = {a[0], a[16:1]};
        return int'(a) % VRAM_BYTES;
    endfunction

    // Post-increment the counter; a wrap bumps the bank when the mode allows it
    function automatic int take_vram_index();
        int idx;
        idx = vram_index(addr_model);
        addr_model = addr_model + 14'd1;
        if (addr_model == 14'd0 && (regs_model[REG_MODE0] & MODE0_WRAP_BITS) != 0)
            regs_model[REG_BANK] = {5'd0, regs_model[REG_BANK][2:0] + 3'd1};
        return idx;
    endfunction

    function automatic logic [7:0] vram_fetch();
        logic [7:0] prev;
        prev = readahead_model;
        ctrl_pend_model = 1'b0;
        readahead_model = vram_model[take_vram_index()];
        return prev;
    endfunction

    function automatic void store_register(input logic [5:0] r, input logic [7:0] v,
                                           inout t_result res);
        res.reg_write_valid = 1'b1;
        res.reg_write_index = r;
        res.reg_write_value = v;
        reg_events++;
        case (r)
            REG_PATGEN:               regs_model[r] = v & 8'h3f;
            REG_TEXT_COLOR, REG_BLINK: ;
            REG_BANK:                 regs_model[r] = v & 8'h07;
            REG_STATUS_PTR:           regs_model[r] = v & 8'h0f;
            REG_PAL_PTR: begin
                regs_model[r] = v & 8'h0f;
                pal_pend_model = 1'b0;
            end
            REG_IND_PTR:              regs_model[r] = v & IND_PTR_MASK;
            default: begin
                if (r < REG_CMD_FIRST || r > REG_CMD_LAST) regs_model[r] = v;
            end
        endcase
    endfunction

    function automatic t_result predict_port_access(input logic [2:0] act,
                                                    input logic [7:0] data);
        t_result res;
        int idx;
        logic [5:0] ptr;
        res = '0;
        case (act)
            ACT_VRAM_RD: res.read_data = vram_fetch();
            ACT_VRAM_WR: begin
                ctrl_pend_model = 1'b0;
                idx = take_vram_index();
                vram_model[idx] = data;
                vram_written[idx] = 1'b1;
                readahead_model = data;
            end
            ACT_CTRL_WR: begin
                if (ctrl_pend_model) begin
                    ctrl_pend_model = 1'b0;
                    if ((data & CTL_REG_SEL) != 0) begin
                        if ((data & CTL_NO_READ) == 0)
                            store_register(data[5:0], data_latch_model, res);
                    end else begin
                        addr_model = {data[5:0], data_latch_model};
                        if ((data & CTL_NO_READ) == 0) void'(vram_fetch());
                    end
                end else begin
                    ctrl_pend_model = 1'b1;
                    data_latch_model = data;
                end
            end
            ACT_PAL_WR: begin
                if (pal_pend_model) begin
                    res.palette_valid  = 1'b1;
                    res.palette_index  = regs_model[REG_PAL_PTR][3:0];
                    res.palette_first  = data_latch_model;
                    res.palette_second = data;
                    regs_model[REG_PAL_PTR] = {4'd0, regs_model[REG_PAL_PTR][3:0] + 4'd1};
                    pal_events++;
                end else begin
                    data_latch_model = data;
                end
                pal_pend_model = !pal_pend_model;
            end
            ACT_INDIR_WR: begin
                ptr = regs_model[REG_IND_PTR][5:0];
                data_latch_model = data;
                if (ptr != REG_IND_PTR) store_register(ptr, data, res);
                if ((regs_model[REG_IND_PTR] & IND_HOLD) == 0)
                    regs_model[REG_IND_PTR] = {2'b00, ptr + 6'd1};
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        err_count++;
        if (err_count <= 40)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    endtask

    // Entered and left at a falling edge; valid stays up when the next item follows at once
    task automatic send_access(input logic [2:0] act, input logic [7:0] data);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        // never read a location that was not written yet
        if (act == ACT_VRAM_RD && !vram_written[vram_index(addr_model)])
            act = ACT_VRAM_WR;
        if (act == ACT_CTRL_WR && ctrl_pend_model && (data & (CTL_REG_SEL | CTL_NO_READ)) == 0
            && !vram_written[vram_index({data[5:0], data_latch_model})])
            data = data | CTL_NO_READ;
        in_ch.valid     = 1'b1;
        in_ch.action    = act;
        in_ch.data_byte = data;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        port_results_q.push_back(predict_port_access(act, data));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic set_vram_address(input logic [13:0] a, input bit for_write);
        send_access(ACT_CTRL_WR, a[7:0]);
        send_access(ACT_CTRL_WR, {1'b0, for_write, a[13:8]});
    endtask

    task automatic write_ctrl_register(input logic [5:0] r, input logic [7:0] v);
        send_access(ACT_CTRL_WR, v);
        send_access(ACT_CTRL_WR, CTL_REG_SEL | {2'b00, r});
    endtask

    task automatic write_address_mode(input bit val);
        in_ch.valid = 1'b0;
        while (port_results_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_data = val;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        interleave_model = val;
        mode_writes++;
    endtask

    task automatic test_vram_access();
        set_vram_address(14'h0000, 1'b1);
        send_access(ACT_VRAM_WR, 8'h00);
        send_access(ACT_VRAM_WR, 8'hff);
        set_vram_address(14'h0000, 1'b0);
        send_access(ACT_VRAM_RD, 8'hff);
    endtask

    task automatic test_register_ports();
        write_ctrl_register(REG_TOP, 8'hff);
        // both mode bits set in the second byte: no effect
        send_access(ACT_CTRL_WR, 8'h5a);
        send_access(ACT_CTRL_WR, CTL_REG_SEL | CTL_NO_READ | 8'h3f);
        write_ctrl_register(REG_IND_PTR, 8'd16);
        send_access(ACT_INDIR_WR, 8'h0f);
        send_access(ACT_INDIR_WR, 8'haa);
    endtask

    task automatic test_palette();
        send_access(ACT_PAL_WR, 8'h00);
        send_access(ACT_PAL_WR, 8'hff);
        send_access(ACT_PAL_WR, 8'h12);
        // pointer write drops the half-written entry
        write_ctrl_register(REG_PAL_PTR, 8'hf5);
        send_access(ACT_PAL_WR, 8'h34);
        send_access(ACT_PAL_WR, 8'h56);
    endtask

    task automatic test_bank_wrap();
        write_ctrl_register(REG_MODE0, 8'h04);
        write_ctrl_register(REG_BANK, 8'h07);
        set_vram_address(14'h3fff, 1'b1);
        send_access(ACT_VRAM_WR, 8'h3c);
        send_access(ACT_VRAM_WR, 8'hc3);
    endtask

    task automatic test_unused_actions();
        for (int k = 0; k < 3; k++) send_access(ACT_UNUSED_LO + 3'(k), 8'hff);
    endtask

    task automatic test_input_stall();
        src_max_gap   = 0;
        snk_max_stall = 0;
        sink_hold_cycles = 120;
        set_vram_address(14'h0200, 1'b1);
        repeat (30) send_access(ACT_VRAM_WR, rand_byte());
        set_vram_address(14'h0200, 1'b0);
        repeat (20) send_access(ACT_VRAM_RD, rand_byte());
    endtask

    task automatic test_random_traffic(input int n_items);
        int first;
        int kind;
        logic [13:0] base;
        first = items_sent;
        while (items_sent - first < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                src_max_gap   = ($urandom_range(0, 2) == 0) ? 0 : 14;
                snk_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 14;
            end
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                case ($urandom_range(0, 3))
                    0:       base = 14'($urandom_range(0, 63));
                    1:       base = 14'h3fff - 14'($urandom_range(0, 15));
                    2:       base = 14'($urandom_range(0, 16383));
                    default: base = 14'h0100 + 14'($urandom_range(0, 31));
                endcase
                if ($urandom_range(0, 4) == 0) write_ctrl_register(REG_BANK, rand_byte());
                if ($urandom_range(0, 4) == 0) write_ctrl_register(REG_MODE0, rand_byte());
                set_vram_address(base, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 12))
                    send_access(($urandom_range(0, 2) == 0) ? ACT_VRAM_WR : ACT_VRAM_RD,
                                rand_byte());
            end else if (kind < 60) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_access(ACT_CTRL_WR, rand_byte());
                    send_access(ACT_CTRL_WR, CTL_REG_SEL | CTL_NO_READ | rand_byte());
                end else begin
                    write_ctrl_register(6'($urandom_range(0, 63)), rand_byte());
                end
            end else if (kind < 75) begin
                if ($urandom_range(0, 3) == 0) write_ctrl_register(REG_PAL_PTR, rand_byte());
                repeat ($urandom_range(1, 4)) begin
                    send_access(ACT_PAL_WR, rand_byte());
                    send_access(ACT_PAL_WR, rand_byte());
                end
                if ($urandom_range(0, 5) == 0) send_access(ACT_PAL_WR, rand_byte());
            end else if (kind < 90) begin
                if ($urandom_range(0, 1) == 0) write_ctrl_register(REG_IND_PTR, rand_byte());
                repeat ($urandom_range(1, 6)) send_access(ACT_INDIR_WR, rand_byte());
            end else begin
                repeat ($urandom_range(1, 3))
                    send_access(3'($urandom_range(0, 4)), rand_byte());
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        int held;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold_cycles > 0) begin
                out_ch.ready = 1'b0;
                for (held = 0; held < sink_hold_cycles; held++) @(negedge clk);
                sink_hold_cycles = 0;
            end
            stall = $urandom_range(0, snk_max_stall);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.read_data       = out_ch.read_data;
            got.reg_write_valid = out_ch.reg_write_valid;
            got.reg_write_index = out_ch.reg_write_index;
            got.reg_write_value = out_ch.reg_write_value;
            got.palette_valid   = out_ch.palette_valid;
            got.palette_index   = out_ch.palette_index;
            got.palette_first   = out_ch.palette_first;
            got.palette_second  = out_ch.palette_second;
            if (port_results_q.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = port_results_q.pop_front();
                results_checked++;
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.reg_write_valid !== want.reg_write_valid)
                    report_mismatch("reg_write_valid", got.reg_write_valid,
                                    want.reg_write_valid);
                if (got.reg_write_index !== want.reg_write_index)
                    report_mismatch("reg_write_index", got.reg_write_index,
                                    want.reg_write_index);
                if (got.reg_write_value !== want.reg_write_value)
                    report_mismatch("reg_write_value", got.reg_write_value,
                                    want.reg_write_value);
                if (got.palette_valid !== want.palette_valid)
                    report_mismatch("palette_valid", got.palette_valid, want.palette_valid);
                if (got.palette_index !== want.palette_index)
                    report_mismatch("palette_index", got.palette_index, want.palette_index);
                if (got.palette_first !== want.palette_first)
                    report_mismatch("palette_first", got.palette_first, want.palette_first);
                if (got.palette_second !== want.palette_second)
                    report_mismatch("palette_second", got.palette_second,
                                    want.palette_second);
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_VRAM_RD;
        in_ch.data_byte = 8'h00;
        foreach (regs_model[i]) regs_model[i] = 8'h00;
        regs_model[REG_MODE2] = 8'h02;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        write_address_mode(1'b0);
        test_vram_access();
        test_register_ports();
        test_palette();
        test_bank_wrap();
        test_unused_actions();
        test_input_stall();

        src_max_gap   = 14;
        snk_max_stall = 14;
        test_random_traffic(300);
        write_address_mode(1'b1);
        test_random_traffic(250);
        write_address_mode(1'b0);
        test_random_traffic(120);

        in_ch.valid = 1'b0;
        while (port_results_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d port accesses, %0d results checked field by field.",
                 items_sent, results_checked);
        $display("Saw %0d register events, %0d palette entries, %0d address mode writes.",
                 reg_events, pal_events, mode_writes);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/vcpi_pkg.sv
rtl/core/vcpi_in_if.sv
rtl/core/vcpi_out_if.sv
rtl/core/vcpi_front.sv
rtl/core/vcpi_fifo.sv
rtl/core/vcpi_back.sv
rtl/core/video_controller_port_interface.sv
sim/tb_video_controller_port_interface.sv
